[rtl/xms_pkg.sv]
package xms_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 41;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_ERASE  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [VALUE_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] best;
        logic [1:0]            status;
    } out_item_t;

    // Memory write request from the scan engine to the store
    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
    } mem_wr_t;

endpackage

[rtl/xms_store.sv]
module xms_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [xms_pkg::ADDR_BITS-1:0]  rd_addr,
    input  xms_pkg::mem_wr_t               wr,
    output logic                           busy,
    output logic                           rd_valid,
    output logic [xms_pkg::VALUE_BITS-1:0] rd_value
);
    import xms_pkg::*;

    // Each word holds the occupancy bit above the stored value
    logic [VALUE_BITS:0] word_mem [CAPACITY];
    logic [ADDR_BITS:0]  clr_reg;

    assign busy = (clr_reg != (ADDR_BITS+1)'(CAPACITY));

    // Advance the clearing pass once after reset, one address per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (busy)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Write one word, registered read
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            word_mem[clr_reg[ADDR_BITS-1:0]] <= '0;
        end
        else if (wr.en)
        begin
            word_mem[wr.addr] <= {wr.valid, wr.value};
        end
        {rd_valid, rd_value} <= word_mem[rd_addr];
    end

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr.en)
        else $error("store write during clearing pass");

endmodule

[rtl/xor_max_set_query_unit.sv]
// Flow: an accepted item is compared against every entry of the store, read
// through its registered read port; then decide, write back and register the result.
// One item is in work at a time; a result waits while the output is not taken.
// The next item is taken while a finished result still waits at the output.
// Reset: asynchronous, active low; clears member count and control, then a
// clearing pass over every store address holds in_ready low.
module xor_max_set_query_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xms_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output xms_pkg::out_item_t out_data
);
    import xms_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t                state_reg, state_next;
    in_item_t              item_reg, item_next;
    logic [ADDR_BITS:0]    addr_reg, addr_next;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  pend_reg, pend_next;
    logic [ADDR_BITS-1:0]  pend_addr_reg, pend_addr_next;
    logic                  hit_reg, hit_next;
    logic [ADDR_BITS-1:0]  hit_addr_reg, hit_addr_next;
    logic                  free_reg, free_next;
    logic [ADDR_BITS-1:0]  free_addr_reg, free_addr_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] top_reg, top_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  ovalid_reg, ovalid_next;
    out_item_t             odata_reg, odata_next;
    logic                  store_busy;
    logic                  rd_valid;
    logic [VALUE_BITS-1:0] rd_value;
    logic [VALUE_BITS-1:0] x;
    mem_wr_t               wr;

    xms_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .wr       (wr),
        .busy     (store_busy),
        .rd_valid (rd_valid),
        .rd_value (rd_value)
    );

    assign rd_addr   = addr_reg[ADDR_BITS-1:0];
    assign in_ready  = (state_reg == S_IDLE) && !store_busy;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign x         = rd_value ^ item_reg.value;

    // Scan every entry, then decide and write back
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = rd_addr;
        hit_next       = hit_reg;
        hit_addr_next  = hit_addr_reg;
        free_next      = free_reg;
        free_addr_next = free_addr_reg;
        found_next     = found_reg;
        top_next       = top_reg;
        best_next      = best_reg;
        count_next     = count_reg;
        ovalid_next    = ovalid_reg;
        odata_next     = odata_reg;
        wr             = '0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        // Evaluate the entry read last cycle
        if (pend_reg)
        begin
            if (rd_valid)
            begin
                if (rd_value == item_reg.value && !hit_reg)
                begin
                    hit_next      = 1'b1;
                    hit_addr_next = pend_addr_reg;
                end
                if (!found_reg || x > top_reg)
                begin
                    found_next = 1'b1;
                    top_next   = x;
                    best_next  = rd_value;
                end
            end
            else if (!free_reg)
            begin
                free_next      = 1'b1;
                free_addr_next = pend_addr_reg;
            end
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next  = in_data;
                    addr_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                pend_next = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == (ADDR_BITS+1)'(CAPACITY - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!pend_reg && (!ovalid_reg || out_ready))
                begin
                    odata_next.best   = '0;
                    odata_next.status = ST_NOCHANGE;
                    case (item_reg.mode)
                        MODE_INSERT:
                        begin
                            if (!hit_reg)
                            begin
                                if (count_reg >= COUNT_BITS'(CAPACITY) || !free_reg)
                                begin
                                    odata_next.status = ST_FULL;
                                end
                                else
                                begin
                                    wr.en    = 1'b1;
                                    wr.addr  = free_addr_reg;
                                    wr.valid = 1'b1;
                                    wr.value = item_reg.value;
                                    count_next = count_reg + 1'b1;
                                    odata_next.status = ST_DONE;
                                end
                            end
                        end
                        MODE_ERASE:
                        begin
                            if (hit_reg)
                            begin
                                wr.en    = 1'b1;
                                wr.addr  = hit_addr_reg;
                                wr.valid = 1'b0;
                                count_next = count_reg - 1'b1;
                                odata_next.status = ST_DONE;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (found_reg)
                            begin
                                odata_next.best   = best_reg;
                                odata_next.status = ST_DONE;
                            end
                            else
                            begin
                                odata_next.status = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            odata_next.status = ST_NOCHANGE;
                        end
                    endcase
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            addr_reg   <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            found_reg  <= 1'b0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
            free_reg   <= free_next;
            found_reg  <= found_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_addr_reg <= pend_addr_next;
        hit_addr_reg  <= hit_addr_next;
        free_addr_reg <= free_addr_next;
        top_reg       <= top_next;
        best_reg      <= best_next;
        odata_reg     <= odata_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(CAPACITY))
        else $error("member count exceeds capacity");

    a_write_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_DONE))
        else $error("store write outside completion");

    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without finished scan");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !in_ready)
        else $error("ready during scan");

endmodule
